@@ rtl/round_robin_resource_allocator_defines.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ROUND_ROBIN_RESOURCE_ALLOCATOR_DEFINES_SVH
`define ROUND_ROBIN_RESOURCE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RRA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rra assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rra assertion failed");

`endif

@@ rtl/rra_pkg.sv @@
package rra_pkg;

    // Built pool size.
    localparam int POOL_SIZE = 8;

    localparam int UNIT_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W   = $clog2(POOL_SIZE + 1);
    localparam int CFG_W   = 4;
    localparam int REQ_W   = 2;
    localparam int ID_W    = 8;
    localparam int OWNER_W = 8;
    localparam int GID_W   = 3;
    localparam int ST_W    = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CNT_W:0]    cnt1_t;

    localparam logic [REQ_W-1:0] REQ_ALLOC      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TUNE_START = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TUNE_STOP  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK            = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_ID        = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_OWNER     = 3'd2;
    localparam logic [ST_W-1:0] ST_ALREADY_TUNED = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_TUNED     = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL          = 3'd5;
    localparam logic [ST_W-1:0] ST_STILL_TUNED   = 3'd6;
    localparam logic [ST_W-1:0] ST_EXT_FAIL      = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ID_W-1:0]    unit_id;
        logic [OWNER_W-1:0] owner_id;
        logic               ext_ok;
    } rra_in_t;

    typedef struct packed {
        logic             ok;
        logic [GID_W-1:0] granted_id;
        logic [ST_W-1:0]  status;
    } rra_out_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic scan_step;
        logic load_out;
    } rra_cmd_t;

    typedef struct packed {
        logic req_alloc;
        logic scan_done;
    } rra_sts_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_OUT    = 4'b1000
    } rra_state_t;

endpackage

@@ rtl/rra_datapath.sv @@
module rra_datapath
    import rra_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  rra_cmd_t       cmd,
    output rra_sts_t       sts,
    input  rra_in_t        req,
    input  logic           cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output rra_out_t       rsp
);

    logic [CFG_W-1:0]     unit_count_reg;
    cnt_t                 eff_reg;
    rra_in_t              req_reg;
    logic [OWNER_W-1:0]   owner_rd_reg;
    logic [POOL_SIZE-1:0] valid_reg;
    logic [POOL_SIZE-1:0] tuned_reg;
    unit_t                ptr_reg;
    cnt_t                 cnt_reg;
    rra_out_t             res_reg;
    rra_out_t             rsp_reg;
    logic [OWNER_W-1:0]   owner_mem [POOL_SIZE];

    cnt_t     eff_now;
    cnt1_t    ptr_inc;
    unit_t    ptr_wrap;
    cnt1_t    cnt_inc;
    logic     scan_free;
    logic     scan_last;
    logic     scan_empty;
    logic     scan_grant;
    unit_t    id_idx;
    logic     bad_id;
    logic     id_valid;
    logic     id_tuned;
    rra_out_t dec_res;
    logic     dec_set_tuned;
    logic     dec_clr_tuned;
    logic     dec_clr_valid;

    // A count above the built pool saturates to the pool size.
    assign eff_now = (ID_W'(unit_count_reg) > ID_W'(POOL_SIZE)) ? cnt_t'(POOL_SIZE)
                                                               : cnt_t'(unit_count_reg);

    assign ptr_inc    = cnt1_t'(ptr_reg) + cnt1_t'(1);
    assign ptr_wrap   = (ptr_inc >= cnt1_t'(eff_reg)) ? '0 : ptr_inc[UNIT_W-1:0];
    assign cnt_inc    = cnt1_t'(cnt_reg) + cnt1_t'(1);
    assign scan_empty = (eff_reg == '0);
    assign scan_free  = !valid_reg[ptr_reg];
    assign scan_last  = (cnt_inc == cnt1_t'(eff_reg));
    assign scan_grant = !scan_empty && scan_free;

    assign sts.req_alloc = (req.req_type == REQ_ALLOC);
    assign sts.scan_done = scan_empty || scan_free || scan_last;

    assign id_idx   = req_reg.unit_id[UNIT_W-1:0];
    assign bad_id   = (req_reg.unit_id >= ID_W'(eff_reg));
    assign id_valid = valid_reg[id_idx];
    assign id_tuned = tuned_reg[id_idx];

    always_comb
    begin
        dec_res       = '{ok: 1'b0, granted_id: '0, status: ST_OK};
        dec_set_tuned = 1'b0;
        dec_clr_tuned = 1'b0;
        dec_clr_valid = 1'b0;
        if (bad_id)
        begin
            dec_res.status = ST_BAD_ID;
        end
        else
        begin
            case (req_reg.req_type)
                REQ_RELEASE:
                begin
                    if (id_tuned)
                    begin
                        dec_res.status = ST_STILL_TUNED;
                    end
                    else
                    begin
                        dec_res.ok    = 1'b1;
                        dec_clr_valid = 1'b1;
                    end
                end
                REQ_TUNE_START:
                begin
                    if (!id_valid || owner_rd_reg != req_reg.owner_id)
                        dec_res.status = ST_NOT_OWNER;
                    else if (id_tuned)
                        dec_res.status = ST_ALREADY_TUNED;
                    else if (!req_reg.ext_ok)
                        dec_res.status = ST_EXT_FAIL;
                    else
                    begin
                        dec_res.ok    = 1'b1;
                        dec_set_tuned = 1'b1;
                    end
                end
                REQ_TUNE_STOP:
                begin
                    if (!id_valid || owner_rd_reg != req_reg.owner_id)
                        dec_res.status = ST_NOT_OWNER;
                    else if (!id_tuned)
                        dec_res.status = ST_NOT_TUNED;
                    else if (!req_reg.ext_ok)
                        dec_res.status = ST_EXT_FAIL;
                    else
                    begin
                        dec_res.ok    = 1'b1;
                        dec_clr_tuned = 1'b1;
                    end
                end
                default:
                begin
                    dec_res.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg <= CFG_RESET;
            valid_reg      <= '0;
            tuned_reg      <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
                unit_count_reg <= cfg_wdata;
            // The scan restarts at unit 0 when the pointer is beyond the count.
            if (cmd.capture && req.req_type == REQ_ALLOC && eff_now != '0
                && cnt_t'(ptr_reg) >= eff_now)
                ptr_reg <= '0;
            if (cmd.scan_step && !scan_empty)
            begin
                ptr_reg <= ptr_wrap;
                if (scan_free)
                begin
                    valid_reg[ptr_reg] <= 1'b1;
                    tuned_reg[ptr_reg] <= 1'b0;
                end
            end
            if (cmd.decide)
            begin
                if (dec_clr_valid)
                begin
                    valid_reg[id_idx] <= 1'b0;
                    tuned_reg[id_idx] <= 1'b0;
                end
                if (dec_set_tuned)
                    tuned_reg[id_idx] <= 1'b1;
                if (dec_clr_tuned)
                    tuned_reg[id_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            eff_reg <= eff_now;
            cnt_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            cnt_reg <= cnt_inc[CNT_W-1:0];
            if (scan_grant)
                res_reg <= '{ok: 1'b1, granted_id: GID_W'(ptr_reg), status: ST_OK};
            else if (scan_empty || scan_last)
                res_reg <= '{ok: 1'b0, granted_id: '0, status: ST_FULL};
        end
        if (cmd.decide)
            res_reg <= dec_res;
        if (cmd.load_out)
            rsp_reg <= res_reg;
    end

    // Owner table: one write port for grants, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && scan_grant)
            owner_mem[ptr_reg] <= req_reg.owner_id;
        if (cmd.capture)
            owner_rd_reg <= owner_mem[req.unit_id[UNIT_W-1:0]];
    end

    assign rsp = rsp_reg;

endmodule

@@ rtl/rra_ctrl.sv @@
module rra_ctrl
    import rra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  rra_sts_t sts,
    output rra_cmd_t cmd
);

    rra_state_t state_reg;
    rra_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.req_alloc ? S_SCAN : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // The result waits here until the output register is free.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/round_robin_resource_allocator.sv @@
// Round-robin allocator for a pool of identical units.
// Requests enter on req/req_valid/req_stall and each produces exactly one
// response on rsp/rsp_valid/rsp_stall; a transaction completes when valid is
// high and stall is low. The unit count register is written through cfg_we
// and cfg_wdata; the user must write it only while no request is in flight,
// as the block itself does not enforce it. One request is worked on at a time,
// and req_stall stays high from acceptance until its response is loaded into
// the output register. Release and tune requests pass from a decide state to
// an output state, which loads the output register. An allocate scans the
// pool one unit per cycle from the round-robin pointer, inspecting from 1 up
// to the unit count of units (at most 8, and 1 when the count is zero), and
// then moves to the output state.
// The response sits in an output register; while the receiver stalls it holds
// there, and a finished result waits inside the block with req_stall high until
// the register is taken.
// Reset frees every unit, clears the tuned flags, sets the pointer to unit 0
// and the unit count to 8.
module round_robin_resource_allocator
    import rra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  rra_in_t          req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rra_out_t         rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    rra_cmd_t cmd;
    rra_sts_t sts;

    rra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rra_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule

@@ rtl/rra_checker.sv @@
`include "round_robin_resource_allocator_defines.svh"

module rra_checker
    import rra_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input rra_out_t rsp
);

    // A stalled response holds.
    `RRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // Success and the OK status always go together.
    `RRA_ASSERT_SAME(a_ok_status, rsp_valid, rsp.ok == (rsp.status == ST_OK))

    // Only a successful allocate names a unit.
    `RRA_ASSERT_SAME(a_gid_ok, rsp_valid && rsp.granted_id != '0, rsp.ok)

    // The block works on one request at a time.
    `RRA_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall)

endmodule

bind round_robin_resource_allocator rra_checker u_rra_checker (.*);

@@ sim/tb_round_robin_resource_allocator.sv @@
module tb_round_robin_resource_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import rra_pkg::*;

    localparam int HANG_LIMIT = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    rra_in_t          req = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rra_out_t         rsp;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    round_robin_resource_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Shadow of the allocator state, advanced as each request is accepted.
    logic             unit_busy [POOL_SIZE];
    logic [ID_W-1:0]  unit_holder [POOL_SIZE];
    logic             unit_tuned [POOL_SIZE];
    int               scan_ptr = 0;
    int               unit_limit = int'(CFG_RESET);

    rra_in_t  request_queue [$];
    rra_out_t expected_rsp [$];

    int issued = 0;
    int taken = 0;
    int responses = 0;
    int errors = 0;
    int grants = 0;
    int settings = 0;
    int idle_cycles = 0;
    int status_hits [8];

    // Sender and receiver pacing.
    int       gap_left = 0;
    int       burst_left = 1;
    int       stall_mode = 0;
    int       mode_left = 0;
    int       run_left = 0;
    logic     run_stalled = 1'b0;
    logic     next_stall;
    rra_out_t predicted;
    rra_out_t want;

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            unit_busy[i] = 1'b0;
            unit_holder[i] = '0;
            unit_tuned[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
        begin
            status_hits[i] = 0;
        end
    end

    function automatic int usable_units();
        return (unit_limit > POOL_SIZE) ? POOL_SIZE : unit_limit;
    endfunction

    task automatic compute_response(input rra_in_t t, output rra_out_t r);
        int  n;
        int  u;
        int  id;
        bit  found;
        n = usable_units();
        id = int'(t.unit_id);
        r = '0;
        r.status = ST_OK;
        if (t.req_type == REQ_ALLOC)
        begin
            found = 1'b0;
            if (n > 0)
            begin
                if (scan_ptr >= n)
                begin
                    scan_ptr = 0;
                end
                for (int i = 0; i < n && !found; i++)
                begin
                    u = scan_ptr;
                    scan_ptr = (u + 1 >= n) ? 0 : u + 1;
                    if (!unit_busy[u])
                    begin
                        unit_busy[u] = 1'b1;
                        unit_holder[u] = t.owner_id;
                        unit_tuned[u] = 1'b0;
                        r.ok = 1'b1;
                        r.granted_id = GID_W'(u);
                        found = 1'b1;
                    end
                end
            end
            if (!found)
            begin
                r.status = ST_FULL;
            end
        end
        else if (id >= n)
        begin
            r.status = ST_BAD_ID;
        end
        else if (t.req_type == REQ_RELEASE)
        begin
            if (unit_tuned[id])
            begin
                r.status = ST_STILL_TUNED;
            end
            else
            begin
                unit_busy[id] = 1'b0;
                unit_holder[id] = '0;
                unit_tuned[id] = 1'b0;
                r.ok = 1'b1;
            end
        end
        else if (!unit_busy[id] || unit_holder[id] != t.owner_id)
        begin
            r.status = ST_NOT_OWNER;
        end
        else if (t.req_type == REQ_TUNE_START)
        begin
            if (unit_tuned[id])
            begin
                r.status = ST_ALREADY_TUNED;
            end
            else if (!t.ext_ok)
            begin
                r.status = ST_EXT_FAIL;
            end
            else
            begin
                unit_tuned[id] = 1'b1;
                r.ok = 1'b1;
            end
        end
        else
        begin
            if (!unit_tuned[id])
            begin
                r.status = ST_NOT_TUNED;
            end
            else if (!t.ext_ok)
            begin
                r.status = ST_EXT_FAIL;
            end
            else
            begin
                unit_tuned[id] = 1'b0;
                r.ok = 1'b1;
            end
        end
    endtask

    function automatic rra_in_t make_req(logic [REQ_W-1:0] rt, int id, int owner,
                                         bit ext);
        rra_in_t t;
        t.req_type = rt;
        t.unit_id = ID_W'(id);
        t.owner_id = OWNER_W'(owner);
        t.ext_ok = ext;
        return t;
    endfunction

    // Mostly addresses usable units with the owner that holds them, so that
    // tune requests get past the ownership check; the rest is noise.
    function automatic rra_in_t random_request();
        rra_in_t t;
        int      n;
        int      roll;
        n = usable_units();
        t.ext_ok = ($urandom_range(0, 99) < 85);
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            t.req_type = REQ_ALLOC;
        end
        else if (roll < 50)
        begin
            t.req_type = REQ_RELEASE;
        end
        else if (roll < 75)
        begin
            t.req_type = REQ_TUNE_START;
        end
        else
        begin
            t.req_type = REQ_TUNE_STOP;
        end
        roll = $urandom_range(0, 9);
        if (n > 0 && roll < 8)
        begin
            t.unit_id = ID_W'($urandom_range(0, n - 1));
        end
        else if (roll == 8)
        begin
            t.unit_id = ID_W'($urandom_range(0, 255));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: t.unit_id = ID_W'(n);
                1: t.unit_id = '1;
                2: t.unit_id = ID_W'(POOL_SIZE);
                default: t.unit_id = ID_W'(POOL_SIZE - 1);
            endcase
        end
        t.owner_id = OWNER_W'($urandom_range(0, 255));
        if ((t.req_type == REQ_TUNE_START || t.req_type == REQ_TUNE_STOP)
                && t.unit_id < POOL_SIZE && $urandom_range(0, 3) != 0)
        begin
            t.owner_id = unit_holder[t.unit_id];
        end
        else if (t.req_type == REQ_ALLOC && $urandom_range(0, 3) == 0)
        begin
            t.owner_id = $urandom_range(0, 1) ? '1 : '0;
        end
        return t;
    endfunction

    task automatic enqueue(input rra_in_t t);
        request_queue.push_back(t);
        issued++;
    endtask

    // Polls on the falling edge so that counters updated at the rising edge
    // are settled.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (taken != issued || expected_rsp.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_unit_count(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        unit_limit = int'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Driver: a stalled transaction is held; otherwise the next request goes
    // out unless the sender is between bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                compute_response(req, predicted);
                expected_rsp.push_back(predicted);
                status_hits[predicted.status]++;
                if (req.req_type == REQ_ALLOC && predicted.ok)
                begin
                    grants++;
                end
                taken++;
            end
            if (!(req_valid && req_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    req <= request_queue.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between no stalls, scattered stalls and stall runs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 200);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: next_stall = 1'b0;
                1: next_stall = ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_stalled = !run_stalled;
                        run_left = run_stalled ? $urandom_range(1, 10)
                                               : $urandom_range(1, 6);
                    end
                    else
                    begin
                        run_left--;
                    end
                    next_stall = run_stalled;
                end
            endcase
            rsp_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            responses++;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("response %0d arrived with none outstanding: %s%0d%s%0d%s%0d",
                             responses, "ok=", rsp.ok, " gid=", rsp.granted_id,
                             " st=", rsp.status);
                end
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.ok !== want.ok || rsp.granted_id !== want.granted_id
                        || rsp.status !== want.status)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("response %0d: expected ok=%0d gid=%0d st=%0d, %s%0d%s%0d%s%0d",
                                 responses, want.ok, want.granted_id, want.status,
                                 "got ok=", rsp.ok, " gid=", rsp.granted_id,
                                 " st=", rsp.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("no transaction for %0d cycles", HANG_LIMIT);
                $display("round_robin_resource_allocator: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0] counts [10];
        int               lengths [10];
        counts = '{4'd3, 4'd1, 4'd0, 4'd15, 4'd8, 4'd5, 4'd2, 4'd9, 4'd6, 4'd7};
        lengths = '{140, 120, 40, 140, 150, 130, 120, 130, 130, 130};

        // Fill the pool with assorted owners, then walk through every outcome.
        for (int k = 0; k < 8; k++)
        begin
            enqueue(make_req(REQ_ALLOC, 255 - k, (k == 1) ? 255 : k * 17, k % 2));
        end
        enqueue(make_req(REQ_ALLOC, 0, 8'h5a, 1'b1));
        enqueue(make_req(REQ_TUNE_START, 1, 255, 1'b1));
        enqueue(make_req(REQ_TUNE_START, 1, 255, 1'b1));
        enqueue(make_req(REQ_TUNE_START, 2, 34, 1'b0));
        enqueue(make_req(REQ_TUNE_START, 2, 0, 1'b1));
        enqueue(make_req(REQ_RELEASE, 1, 0, 1'b1));
        enqueue(make_req(REQ_TUNE_STOP, 3, 51, 1'b1));
        enqueue(make_req(REQ_TUNE_STOP, 1, 255, 1'b0));
        enqueue(make_req(REQ_TUNE_STOP, 1, 255, 1'b1));
        enqueue(make_req(REQ_RELEASE, 1, 0, 1'b0));
        // Releasing a unit that is already free still succeeds.
        enqueue(make_req(REQ_RELEASE, 1, 255, 1'b1));
        enqueue(make_req(REQ_TUNE_START, 1, 0, 1'b1));
        enqueue(make_req(REQ_RELEASE, 8, 0, 1'b0));
        enqueue(make_req(REQ_TUNE_STOP, 255, 255, 1'b1));
        enqueue(make_req(REQ_ALLOC, 0, 8'ha5, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Each phase starts from an idle block, so the sender also pauses
        // here until every outstanding response has come back.
        for (int p = 0; p < 10; p++)
        begin
            write_unit_count(counts[p]);
            for (int k = 0; k < lengths[p]; k++)
            begin
                while (request_queue.size() >= 2)
                begin
                    @(negedge clk);
                end
                enqueue(random_request());
            end
            wait_drained();
        end

        repeat (12) @(posedge clk);
        $display("covered %0d requests with %0d grants over %0d unit-count settings",
                 taken, grants, settings);
        $display("status counts: ok %0d, bad id %0d, not owner %0d, %s%0d%s%0d%s%0d%s%0d%s%0d",
                 status_hits[0], status_hits[1], status_hits[2],
                 "already tuned ", status_hits[3], ", not tuned ", status_hits[4],
                 ", full ", status_hits[5], ", still tuned ", status_hits[6],
                 ", ext fail ", status_hits[7]);
        if (errors == 0 && expected_rsp.size() == 0)
        begin
            $display("round_robin_resource_allocator: match");
        end
        else
        begin
            $display("round_robin_resource_allocator: mismatch");
        end
        $finish;
    end

endmodule
